// File: design/fprcp_pkg.sv
// ----------------------------------------------------------------------------
// fprcp_pkg
// Types, constants and single precision arithmetic helpers for the
// reciprocal unit: polynomial coefficients, pipeline operation plan,
// multiply, add and round-to-nearest-even.
// ----------------------------------------------------------------------------
`default_nettype none

package fprcp_pkg;

    localparam int N_COEF       = 8;
    localparam int NEWTON_STEPS = 2;
    localparam int N_OPS        = 2 * (N_COEF - 1) + 1 + 3 * NEWTON_STEPS;
    localparam int N_STG        = 1 + 2 * N_OPS;

    localparam logic [31:0] EXP_SUM        = 32'd253;
    localparam logic [31:0] KEEP_SIGN_FRAC = 32'h807F_FFFF;
    localparam logic [31:0] EXP_127        = 32'h3F80_0000;
    localparam logic [7:0]  EXP_MASK       = 8'hFF;
    localparam logic [31:0] FP_TWO         = 32'h4000_0000;
    localparam logic [31:0] FP_QNAN        = 32'h7FC0_0000;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;

    // constant term first
    localparam logic [31:0] COEF [N_COEF] = '{
        32'h40B6_6455, 32'hC161_72D0, 32'h419D_DDF0, 32'hC188_FEAB,
        32'h4116_E04B, 32'hC04D_F6A1, 32'h3F1F_5741, 32'hBD55_FBF4
    };

    typedef enum logic [2:0] {
        OP_MUL_M,
        OP_ADD_C,
        OP_SPLICE,
        OP_MUL_T,
        OP_SUB_U,
        OP_MUL_R
    } op_t;

    typedef enum logic [1:0] {
        SP_FIN,
        SP_INF,
        SP_NAN
    } sp_t;

    // value = sig * 2^(mexp - 173)
    typedef struct packed {
        sp_t                spec;
        logic               sgn;
        logic signed [10:0] mexp;
        logic [49:0]        sig;
    } mid_t;

    typedef struct packed {
        logic        sgn;
        logic [1:0]  status;
        logic [30:0] mag;
        logic [31:0] r;
        logic [31:0] w;
        mid_t        mid;
    } stg_t;

    function automatic op_t op_kind(input int k);
        int j;
        op_t o;
        j = k - 2 * (N_COEF - 1) - 1;
        if (k < 2 * (N_COEF - 1))
            o = (k % 2 == 0) ? OP_MUL_M : OP_ADD_C;
        else if (k == 2 * (N_COEF - 1))
            o = OP_SPLICE;
        else if (j % 3 == 0)
            o = OP_MUL_T;
        else if (j % 3 == 1)
            o = OP_SUB_U;
        else
            o = OP_MUL_R;
        return o;
    endfunction

    function automatic logic [31:0] op_coef(input int k);
        int idx;
        idx = N_COEF - 2 - k / 2;
        if (idx < 0)
            idx = 0;
        return COEF[idx];
    endfunction

    function automatic mid_t fp_mul(input logic [31:0] a, input logic [31:0] b);
        mid_t        m;
        logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
        logic [7:0]  ea, eb;
        logic [23:0] ma, mb;
        logic [47:0] prod;
        a_nan  = (a[30:23] == EXP_MASK) && (a[22:0] != 23'd0);
        b_nan  = (b[30:23] == EXP_MASK) && (b[22:0] != 23'd0);
        a_inf  = (a[30:23] == EXP_MASK) && (a[22:0] == 23'd0);
        b_inf  = (b[30:23] == EXP_MASK) && (b[22:0] == 23'd0);
        a_zero = (a[30:0] == 31'd0);
        b_zero = (b[30:0] == 31'd0);
        ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
        ma = {(a[30:23] != 8'd0), a[22:0]};
        mb = {(b[30:23] != 8'd0), b[22:0]};
        prod   = ma * mb;
        m.sgn  = a[31] ^ b[31];
        m.mexp = $signed({3'b000, ea}) + $signed({3'b000, eb}) - 11'sd127;
        m.sig  = {2'b00, prod};
        if (a_nan || b_nan || (a_inf && b_zero) || (a_zero && b_inf))
            m.spec = SP_NAN;
        else if (a_inf || b_inf)
            m.spec = SP_INF;
        else
            m.spec = SP_FIN;
        return m;
    endfunction

    function automatic mid_t fp_add(input logic [31:0] a, input logic [31:0] b);
        mid_t        m;
        logic        a_nan, b_nan, a_inf, b_inf, swap;
        logic [31:0] big, sml;
        logic [7:0]  eL, eS, d;
        logic [49:0] sigL, full, shf, msk, sum;
        logic        stk;
        a_nan = (a[30:23] == EXP_MASK) && (a[22:0] != 23'd0);
        b_nan = (b[30:23] == EXP_MASK) && (b[22:0] != 23'd0);
        a_inf = (a[30:23] == EXP_MASK) && (a[22:0] == 23'd0);
        b_inf = (b[30:23] == EXP_MASK) && (b[22:0] == 23'd0);
        swap = (b[30:0] > a[30:0]);
        big  = swap ? b : a;
        sml  = swap ? a : b;
        eL = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        eS = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
        d  = eL - eS;
        sigL = {3'b000, (big[30:23] != 8'd0), big[22:0], 23'd0};
        full = {3'b000, (sml[30:23] != 8'd0), sml[22:0], 23'd0};
        if (d >= 8'd50)
        begin
            shf = 50'd0;
            stk = (full != 50'd0);
        end
        else
        begin
            msk = (50'd1 << d) - 50'd1;
            shf = full >> d;
            stk = ((full & msk) != 50'd0);
        end
        shf[0] = shf[0] | stk;
        sum = (big[31] == sml[31]) ? (sigL + shf) : (sigL - shf);
        m.sig  = sum;
        m.mexp = $signed({3'b000, eL});
        m.sgn  = (sum == 50'd0) ? (a[31] & b[31]) : big[31];
        if (a_nan || b_nan || (a_inf && b_inf && (a[31] != b[31])))
        begin
            m.spec = SP_NAN;
        end
        else if (a_inf || b_inf)
        begin
            m.spec = SP_INF;
            m.sgn  = a_inf ? a[31] : b[31];
        end
        else
        begin
            m.spec = SP_FIN;
        end
        return m;
    endfunction

    function automatic logic [31:0] fp_round(input mid_t m);
        logic [31:0]        res;
        logic [5:0]         lead;
        logic signed [12:0] be, s;
        logic               normal, rnd, stk, inc;
        logic [23:0]        kept;
        logic [50:0]        ext, msk;
        logic [7:0]         be_used;
        logic [31:0]        packed_v;
        lead = 6'd0;
        for (int j = 0; j < 50; j++)
        begin
            if (m.sig[j])
                lead = 6'(j);
        end
        be     = 13'(m.mexp) + $signed({7'b0, lead}) - 13'sd46;
        normal = (be >= 13'sd1);
        s      = normal ? ($signed({7'b0, lead}) - 13'sd23) : (13'sd24 - 13'(m.mexp));
        kept = 24'd0;
        rnd  = 1'b0;
        stk  = 1'b0;
        if (s < 13'sd0)
        begin
            kept = 24'(m.sig << 6'(-s));
        end
        else if (s > 13'sd50)
        begin
            stk = (m.sig != 50'd0);
        end
        else
        begin
            ext  = {m.sig, 1'b0} >> 6'(s);
            msk  = ((51'd1 << 6'(s)) - 51'd1) >> 1;
            kept = ext[24:1];
            rnd  = ext[0];
            stk  = ((m.sig & msk[49:0]) != 50'd0);
        end
        inc      = rnd & (stk | kept[0]);
        be_used  = normal ? 8'(be - 13'sd1) : 8'd0;
        packed_v = {1'b0, be_used, 23'd0} + {8'd0, kept} + {31'd0, inc};
        if (m.spec == SP_NAN)
            res = FP_QNAN;
        else if (m.spec == SP_INF || (normal && be >= 13'sd255))
            res = {m.sgn, EXP_MASK, 23'd0};
        else if (m.sig == 50'd0)
            res = {m.sgn, 31'd0};
        else
            res = {m.sgn, packed_v[30:0]};
        return res;
    endfunction

    function automatic stg_t classify(input logic [31:0] x);
        stg_t       s;
        logic [7:0] e;
        e = x[30:23];
        s.sgn = x[31];
        s.mag = x[30:0];
        s.r   = 32'd0;
        s.w   = COEF[N_COEF - 1];
        s.mid = '0;
        if (e == EXP_MASK || x[30:0] == 31'd0)
            s.status = ST_INVALID;
        else if (e == 8'd0 || {24'd0, e} >= EXP_SUM)
            s.status = ST_RANGE;
        else
            s.status = ST_OK;
        return s;
    endfunction

    // first half of an operation: multiply or align and add
    function automatic stg_t stage_a(input op_t op, input stg_t s, input logic [31:0] c);
        stg_t n;
        n = s;
        case (op)
            OP_MUL_M: n.mid = fp_mul(s.w, (({1'b0, s.mag} & KEEP_SIGN_FRAC) | EXP_127));
            OP_ADD_C: n.mid = fp_add(s.w, c);
            OP_MUL_T: n.mid = fp_mul({1'b0, s.mag}, s.r);
            OP_SUB_U: n.mid = fp_add(FP_TWO, {~s.w[31], s.w[30:0]});
            OP_MUL_R: n.mid = fp_mul(s.r, s.w);
            default:  n.mid = s.mid;
        endcase
        return n;
    endfunction

    // second half: normalise and round, or splice the seed exponent
    function automatic stg_t stage_b(input op_t op, input stg_t s);
        stg_t        n;
        logic [31:0] rv;
        logic [7:0]  ne;
        n  = s;
        rv = fp_round(s.mid);
        ne = 8'(EXP_SUM - {24'd0, s.mag[30:23]});
        case (op)
            OP_SPLICE: n.r = (s.w & KEEP_SIGN_FRAC) | {1'b0, ne, 23'd0};
            OP_MUL_R:  n.r = rv;
            default:   n.w = rv;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

// File: design/fp32_reciprocal_poly_newton_unit.sv
// ----------------------------------------------------------------------------
// fp32_reciprocal_poly_newton_unit
// Single precision reciprocal: polynomial seed on the mantissa, exponent
// rebuilt as 253 - e, Newton-Raphson refinement, sign applied last.
// ----------------------------------------------------------------------------
// Fully pipelined: one operand beat is taken every cycle unless the output
// stall has filled every stage. Each beat passes one classify stage, then two
// stages for each of the 21 float operations: seven Horner multiply/add pairs,
// the exponent splice and three operations per refinement step; a multiply or
// add spends one on the product or alignment add, one on normalise and round.
// Empty stages are filled while the output is stalled, so the input keeps
// taking beats until every stage holds an item. Zero, NaN and infinity give
// status 1, denormal inputs and exponent fields of 253 or 254 give status 2,
// and in both cases the result is 0.
`default_nettype none

module fp32_reciprocal_poly_newton_unit
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [31:0] x_bits,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      result_bits,
    output logic [1:0]       status
);
    import fprcp_pkg::*;

    stg_t stg_reg  [N_STG];
    stg_t stg_next [N_STG];
    logic [N_STG-1:0] vld_reg;
    logic [N_STG-1:0] en;

    assign stg_next[0] = classify(x_bits);

    for (genvar k = 0; k < N_OPS; k++)
    begin : g_op
        assign stg_next[2*k+1] = stage_a(op_kind(k), stg_reg[2*k], op_coef(k));
        assign stg_next[2*k+2] = stage_b(op_kind(k), stg_reg[2*k+1]);
    end

    // a stage moves when it is empty or the one after it moves
    always_comb
    begin
        en[N_STG-1] = !vld_reg[N_STG-1] || !out_stall;
        for (int i = N_STG - 2; i >= 0; i--)
            en[i] = !vld_reg[i] || en[i+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
                vld_reg[0] <= in_valid;
            for (int i = 1; i < N_STG; i++)
            begin
                if (en[i])
                    vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < N_STG; i++)
        begin
            if (en[i])
                stg_reg[i] <= stg_next[i];
        end
    end

    assign in_stall    = !en[0];
    assign out_valid   = vld_reg[N_STG-1];
    assign status      = stg_reg[N_STG-1].status;
    assign result_bits = (stg_reg[N_STG-1].status != ST_OK) ? 32'd0 :
                         (stg_reg[N_STG-1].r ^ {stg_reg[N_STG-1].sgn, 31'd0});

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_OK) |-> result_bits == 32'd0)
        else $error("error beat with non-zero result");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_OK) || (status == ST_INVALID) || (status == ST_RANGE))
        else $error("undefined status code");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall && (&vld_reg))
        else $error("input stalled with room in the pipe");

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> vld_reg[0])
        else $error("accepted beat lost at entry");

endmodule

`default_nettype wire
